[hdl/buddy_block_allocator_assert.svh]
// Assertion macros for the buddy block allocator checker.
// Included by the checker module; depends on nothing else.
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BBA_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

[hdl/bba_pkg.sv]
// Package for the buddy block allocator: status codes, controller states,
// table entry layout and controller/datapath command and status structs.
`default_nettype none
package bba_pkg;
  localparam int unsigned TBL_W = 6;
  localparam int unsigned ALLOC_BIT = 4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_NOT_START = 3'd3,
    ST_NOT_ALLOC = 3'd4,
    ST_BAD_CFG   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN,
    S_SPLIT,
    S_FREE_RD,
    S_FREE_CHK,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_DONE
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // latch the input item
    logic clr_wr;     // write clearing pass entry
    logic clr_inc;
    logic scan_start;
    logic scan_step;  // consume one read entry and advance
    logic split_step;
    logic alloc_mark;
    logic free_mark;
    logic merge_rd;
    logic merge_step;
    logic set_result;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic found;
    logic split_more;
    logic pre_err;      // request check failed
    logic free_bad;     // entry not a start or not allocated
    logic merge_more;   // another merge level possible
    logic merge_ok;     // buddy mergeable
  } sts_t;
endpackage
`default_nettype wire

[hdl/bba_if.sv]
// Valid/ready channel interface for the buddy block allocator.
// Payload width given by parameter; no package dependency.
`default_nettype none
interface bba_if #(parameter int W = 1) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/bba_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  // Write or read one entry per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[hdl/bba_ctrl.sv]
// Controller state machine for the buddy block allocator.
// Depends on bba_pkg.
`default_nettype none
module bba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          in_valid,
  input  logic          in_action,
  output logic          in_ready,
  output logic          out_load,
  input  logic          out_free,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd
);
  import bba_pkg::*;
  state_t state, state_next;

  // Hold state.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        cmd.clr_inc = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          cmd.load = 1'b1;
          state_next = in_action ? S_FREE_RD : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.pre_err) begin
          state_next = S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (!sts.found) begin
          state_next = S_DONE;
        end else if (sts.split_more) begin
          cmd.split_step = 1'b1;
        end else begin
          cmd.alloc_mark = 1'b1;
          state_next = S_DONE;
        end
      end
      S_FREE_RD: begin
        state_next = sts.pre_err ? S_DONE : S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (sts.free_bad) begin
          state_next = S_DONE;
        end else begin
          cmd.free_mark = 1'b1;
          state_next = sts.merge_more ? S_MERGE_RD : S_DONE;
        end
      end
      S_MERGE_RD: begin
        cmd.merge_rd = 1'b1;
        state_next = S_MERGE_CHK;
      end
      S_MERGE_CHK: begin
        if (sts.merge_ok) begin
          cmd.merge_step = 1'b1;
          state_next = sts.merge_more ? S_MERGE_RD : S_DONE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.set_result = 1'b1;
        out_load = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[hdl/bba_dp.sv]
// Datapath for the buddy block allocator: configuration, block table RAM,
// scan, split and merge registers. Depends on bba_pkg and bba_ram.
`default_nettype none
module bba_dp #(
  parameter int LEVELS = 8,
  parameter int HEAP_LOG_MAX = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [0:0]     cfg_index,
  input  logic [4:0]     cfg_data,
  input  logic           in_action,
  input  logic [16:0]    in_request_bytes,
  input  logic [15:0]    in_block_offset,
  input  bba_pkg::cmd_t  cmd,
  output bba_pkg::sts_t  sts,
  output logic [2:0]     res_status,
  output logic [15:0]    res_offset,
  output logic [4:0]     res_log
);
  import bba_pkg::*;
  localparam int AW = LEVELS;
  localparam int RW = $clog2(LEVELS + 2);

  logic [4:0] heap_log, min_log;
  logic       cfg_ok;
  logic [4:0] min_eff;
  logic [RW-1:0] top;  // heap_log - min_eff

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_log <= 5'd16;
      min_log  <= 5'd8;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) begin
        heap_log <= cfg_data;
      end else begin
        min_log <= cfg_data;
      end
    end
  end

  // Derive effective unit size.
  always_comb begin
    logic [5:0] dif;
    cfg_ok = (32'(heap_log) <= HEAP_LOG_MAX) && (min_log <= heap_log);
    dif = {1'b0, heap_log} - 6'(LEVELS);
    min_eff = min_log;
    if (32'(heap_log) > LEVELS && dif[4:0] > min_log) begin
      min_eff = dif[4:0];
    end
    if (!cfg_ok) begin
      min_eff = '0;
    end
    top = RW'(heap_log - min_eff);
  end

  // Latched request.
  logic        act;
  logic [16:0] req;
  logic [15:0] off;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= in_action;
      req <= in_request_bytes;
      off <= in_block_offset;
    end
  end

  // Ceiling log2 of request.
  logic [4:0] k_raw;
  always_comb begin
    logic [16:0] m;
    m = req - 17'd1;
    k_raw = '0;
    for (int b = 0; b < 17; b++) begin
      if (m[b]) begin
        k_raw = 5'(b + 1);
      end
    end
  end
  logic [4:0]    k;
  logic [RW-1:0] rel;
  assign k   = (k_raw < min_eff) ? min_eff : k_raw;
  assign rel = RW'(k - min_eff);

  // Request checks.
  logic [2:0] pre_code;
  logic [AW-1:0] fidx;
  always_comb begin
    logic [31:0] mask;
    mask = (32'd1 << min_eff) - 32'd1;
    fidx = AW'(32'(off) >> min_eff);
    pre_code = ST_OK;
    if (!cfg_ok) begin
      pre_code = ST_BAD_CFG;
    end else if (!act) begin
      if (req == '0 || k_raw > heap_log) begin
        pre_code = ST_BAD_SIZE;
      end
    end else if (32'(off) >= (32'd1 << heap_log) || (32'(off) & mask) != 0) begin
      pre_code = ST_NOT_START;
    end
  end

  // Table RAM port.
  logic           we;
  logic [AW-1:0]  addr;
  logic [TBL_W-1:0] wdata, rdata;
  bba_ram #(.WIDTH(TBL_W), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic [AW:0]   cnt;     // clear and scan counter
  logic [AW-1:0] best, cur;
  logic [RW-1:0] best_rel, crel;
  logic          found;
  logic          freed;   // free passed its entry check
  logic [AW:0]   units;
  assign units = (AW+1)'(1) << top;

  logic [AW-1:0] bud;
  assign bud = cur ^ AW'((AW+1)'(1) << crel);

  logic [3:0]    rsz;
  assign rsz = rdata[3:0];

  // RAM address and write data; a free keeps its entry addressed while idle.
  always_comb begin
    we = 1'b0;
    addr = act ? fidx : cnt[AW-1:0];
    wdata = '0;
    if (cmd.clr_wr) begin
      we = 1'b1;
      addr = cnt[AW-1:0];
      wdata = (cnt == '0 && cfg_ok) ? TBL_W'(top + 1'b1) : '0;
    end else if (cmd.split_step) begin
      we = 1'b1;
      addr = best + AW'((AW+1)'(1) << (best_rel - 1'b1));
      wdata = TBL_W'(best_rel);
    end else if (cmd.alloc_mark) begin
      we = 1'b1;
      addr = best;
      wdata = TBL_W'(rel + 1'b1) | TBL_W'(1 << ALLOC_BIT);
    end else if (cmd.free_mark) begin
      we = 1'b1;
      addr = fidx;
      wdata = TBL_W'(rsz);
    end else if (cmd.merge_rd) begin
      addr = bud;
    end else if (cmd.merge_step) begin
      we = 1'b1;
      addr = (bud < cur) ? cur : bud;
    end else if (cmd.set_result && act && freed) begin
      // Write the merged head once the merge loop is over.
      we = 1'b1;
      addr = cur;
      wdata = TBL_W'(crel + 1'b1);
    end else if (cmd.load) begin
      addr = AW'(32'(in_block_offset) >> min_eff);
    end
  end

  // Scan pipeline: entry i's data arrives in the cycle after its address.
  logic [AW:0]   sidx;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      cnt <= '0;
    end else begin
      if (cmd.clr_inc) begin
        cnt <= (cnt == (AW+1)'((1 << AW) - 1)) ? '0 : cnt + 1'b1;
      end else if (cmd.scan_start) begin
        cnt <= (AW+1)'(1);
      end else if (cmd.scan_step) begin
        cnt <= cnt + 1'b1;
        if (sts.scan_last) begin
          cnt <= '0;
        end
      end
    end
  end

  // Track scan result and split/merge registers.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      found <= 1'b0;
      sidx <= '0;
    end
    if (cmd.scan_step) begin
      sidx <= sidx + 1'b1;
      if (rsz != 0 && !rdata[ALLOC_BIT] && RW'(rsz - 1'b1) >= rel
          && (!found || RW'(rsz - 1'b1) < best_rel)) begin
        found <= 1'b1;
        best <= sidx[AW-1:0];
        best_rel <= RW'(rsz - 1'b1);
      end
    end
    if (cmd.split_step) begin
      best_rel <= best_rel - 1'b1;
    end
    if (cmd.load) begin
      cur <= AW'(32'(in_block_offset) >> min_eff);
    end
    if (cmd.free_mark) begin
      crel <= RW'(rsz - 1'b1);
    end
    if (cmd.merge_step) begin
      cur <= (bud < cur) ? bud : cur;
      crel <= crel + 1'b1;
    end
  end

  // Status to controller.
  logic [RW-1:0] frel;
  assign frel = RW'(rsz - 1'b1);
  always_comb begin
    sts = '0;
    sts.clr_last = (cnt == (AW+1)'((1 << AW) - 1));
    sts.scan_last = (sidx + 1'b1 == units);
    sts.found = found;
    sts.split_more = best_rel > rel;
    sts.pre_err = (pre_code != ST_OK);
    sts.free_bad = (rsz == 0) || !rdata[ALLOC_BIT];
    sts.merge_more = cmd.free_mark ? (frel < top) : (crel + 1'b1 < top);
    sts.merge_ok = (rsz == 4'(crel + 1'b1)) && !rdata[ALLOC_BIT];
  end

  // Result registers.
  logic [RW-1:0] last_rel;
  always_comb begin
    last_rel = crel;
  end
  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      res_offset <= '0;
      res_log <= '0;
      if (pre_code != ST_OK) begin
        res_status <= pre_code;
      end else if (!act) begin
        if (!found) begin
          res_status <= ST_NO_FREE;
        end else begin
          res_status <= ST_OK;
          res_offset <= 16'(32'(best) << min_eff);
          res_log <= k;
        end
      end else if (rsz == 0 && !freed) begin
        res_status <= ST_NOT_START;
      end else if (!freed) begin
        res_status <= ST_NOT_ALLOC;
      end else begin
        res_status <= ST_OK;
        res_log <= 5'(last_rel) + min_eff;
      end
    end
  end

  // Remember whether the free passed its entry check.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      freed <= 1'b0;
    end else if (cmd.free_mark) begin
      freed <= 1'b1;
    end
  end
endmodule
`default_nettype wire

[hdl/buddy_block_allocator.sv]
// Buddy block allocator top level: controller, datapath and output register.
// Depends on bba_pkg, bba_if, bba_ctrl, bba_dp.
//
// Use: one request item on req (action, request_bytes, block_offset) gives
// one result item on rsp (status, granted_offset, granted_log). Both are
// valid/ready channels; an item moves when valid and ready are high.
// Allocate: reads the 2^(heap_size_log - unit log) table entries in use
// through the single RAM port, one entry a cycle, then splits the chosen
// block level by level. Free: checks its entry, then reads and merges
// its buddy level by level. A request rejected by its size, offset or the
// configuration goes straight to its result. One item is in work at a time.
// Reset, and any configuration write, starts a clearing pass over the
// 2^LEVELS table entries during which no item is taken. A finished
// result waits in the output register while rsp is stalled; the next
// item is taken only when that register is free.
`default_nettype none
module buddy_block_allocator #(
  parameter int LEVELS = 8,
  parameter int HEAP_LOG_MAX = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [4:0] cfg_data,
  bba_if.sink        req,
  bba_if.source      rsp
);
  import bba_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic out_load;
  logic [2:0]  st;
  logic [15:0] goff;
  logic [4:0]  glog;

  bba_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .in_valid(req.valid),
    .in_action(req.data[0]), .in_ready(req.ready), .out_load(out_load),
    .out_free(!rsp.valid), .sts(sts), .cmd(cmd)
  );

  bba_dp #(.LEVELS(LEVELS), .HEAP_LOG_MAX(HEAP_LOG_MAX)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_action(req.data[0]),
    .in_request_bytes(req.data[17:1]), .in_block_offset(req.data[33:18]),
    .cmd(cmd), .sts(sts), .res_status(st), .res_offset(goff), .res_log(glog)
  );

  // Hold result until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end
  assign rsp.data = {glog, goff, st};
endmodule
`default_nettype wire

[hdl/bba_checker.sv]
// Port-level checker for the buddy block allocator, bound to the top level.
// Depends on buddy_block_allocator_assert.svh.
`default_nettype none
`include "buddy_block_allocator_assert.svh"
module bba_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [23:0] rsp_data
);
  `BBA_ASSERT_IMP(a_stat_range, clk, rst, rsp_valid, rsp_data[2:0] <= 3'd5)
  `BBA_ASSERT_IMP(a_err_zero, clk, rst, rsp_valid && rsp_data[2:0] != 3'd0, rsp_data[23:3] == '0)
  `BBA_ASSERT_IMP(a_no_take_busy, clk, rst, rsp_valid, !req_ready)
  `BBA_ASSERT_NEXT(a_cfg_block, clk, rst, cfg_we, !req_ready)
  `BBA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
endmodule
bind buddy_block_allocator bba_checker u_chk (
  .clk(clk), .rst(rst), .cfg_we(cfg_we),
  .req_ready(req.ready), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_data(rsp.data)
);
`default_nettype wire
